### rtl/bbc_pkg.sv
package bbc_pkg;

    // Default number of cache entries
    localparam int CACHE_ENTRIES_DEF = 8;

    // Field widths
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 32;
    localparam int REF_W  = 8;
    localparam int SLOT_W = 3;

    // Highest reference count; a hit at this count leaves it there
    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

    // Most writebacks one request may emit
    localparam int MAX_WB = 8;
    localparam int WB_W   = 4;

    // Request operations
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_SYNC    = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [2:0] {
        RK_HIT       = 3'd0,
        RK_MISS      = 3'd1,
        RK_WRITEBACK = 3'd2,
        RK_ACK       = 3'd3,
        RK_NO_FREE   = 3'd4,
        RK_BAD_SLOT  = 3'd5
    } kind_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_FINISH,
        ST_SLOT
    } state_t;

    // One entry as held in the tag memory
    typedef struct packed {
        logic             modified;
        logic [REF_W-1:0] refs;
        logic [BLK_W-1:0] block;
        logic [DEV_W-1:0] device;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/bbc_ram.sv
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/block_buffer_cache_tags_core.sv
// Tag and reference-count manager for a fully associative disk block cache.
//
// Requests enter on the s_axis channel: tuser carries the operation (read,
// release, mark modified, sync), tdata the device, block number and slot.
// Results leave on the m_axis channel, one or more per request; tlast marks
// the final one. Writeback results (tlast low) precede the closing result.
//
// The tags sit in one memory with a registered read; the sequencer walks it
// one entry per cycle unless a writeback waits on a stalled m_axis. Steps:
//   release / mark : accept, then read-modify-write of the slot
//   sync           : a pass over all entries
//   read hit       : the walk ends at the matching entry
//   read miss      : a pass over all entries, then a sync pass when none is free
// One request is in work at a time; the next is taken once the closing
// result is in the output register, so it overlaps the wait on the receiver.
// A stall on m_axis holds the walk in place, when it has a result to load,
// until the output register frees.
// Reset marks every entry free through per-entry live bits; the memory
// itself is not cleared, so the block accepts requests right after reset.
module block_buffer_cache_tags_core
    import bbc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // device[7:0], block_number[39:8], slot[42:40]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // slot_index[2:0], target_block[34:3],
                                        // reference_count[42:35]
    output logic [2:0]  m_axis_tuser,   // result_kind[2:0]
    output logic        m_axis_tlast
);

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [IDX_W+2:0] ENTRIES_X = (IDX_W + 3)'(CACHE_ENTRIES);

    // Sequencer and walk state
    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg;
    logic                       free_found_reg;
    logic [IDX_W-1:0]           free_idx_reg;
    logic [WB_W-1:0]            wb_cnt_reg;
    logic [CACHE_ENTRIES-1:0]   live_reg;

    // Latched request
    op_t                        op_reg;
    logic [DEV_W-1:0]           dev_reg;
    logic [BLK_W-1:0]           blk_reg;
    logic [SLOT_W-1:0]          slot_reg;

    // Output register
    logic                       out_valid_reg;
    kind_t                      out_kind_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [BLK_W-1:0]           out_block_reg;
    logic [REF_W-1:0]           out_refs_reg;
    logic                       out_last_reg;

    // Memory ports
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    entry_t                     ram_wdata;
    logic                       ram_re;
    logic [IDX_W-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]         ram_rdata;
    entry_t                     rd;

    // Controls from the output decode
    logic                       accept;
    logic                       emit;
    logic                       emit_ok;
    kind_t                      emit_kind;
    logic [SLOT_W-1:0]          emit_slot;
    logic [BLK_W-1:0]           emit_block;
    logic [REF_W-1:0]           emit_refs;
    logic                       emit_last;
    logic                       idx_clr;
    logic                       idx_inc;
    logic                       live_set;
    logic                       live_clr;
    logic [IDX_W-1:0]           live_idx;
    logic                       free_rec;
    logic                       wb_inc;

    // Decoded conditions
    op_t                        in_op;
    logic [SLOT_W-1:0]          in_slot;
    logic [IDX_W+2:0]           in_slot_x;
    logic [IDX_W+2:0]           slot_x;
    logic [IDX_W-1:0]           slot_idx;
    logic                       slot_in_range;
    logic                       slot_live;
    logic                       slot_bad;
    logic [IDX_W+2:0]           idx_x;
    logic [IDX_W+2:0]           free_x;
    logic                       live_cur;
    logic                       idx_last;
    logic                       scan_hit;
    logic                       sweep_cand;
    logic                       wb_room;
    logic                       sweep_wb;
    logic                       sweep_free;
    logic [REF_W-1:0]           refs_inc;

    bbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd = entry_t'(ram_rdata);

    // Handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit_ok       = !out_valid_reg || m_axis_tready;

    // Request fields
    assign in_op     = op_t'(s_axis_tuser);
    assign in_slot   = s_axis_tdata[42:40];
    assign in_slot_x = {IDX_W'(0), in_slot};
    assign slot_x    = {IDX_W'(0), slot_reg};
    assign slot_idx  = slot_x[IDX_W-1:0];

    // Slot checks for release and mark
    assign slot_in_range = (slot_x < ENTRIES_X);
    assign slot_live     = slot_in_range && live_reg[slot_idx];
    assign slot_bad      = !slot_live || ((op_reg == OP_RELEASE) && (rd.refs == '0));

    // Walk conditions for the entry whose data is on the read port
    assign idx_x      = {3'b000, idx_reg};
    assign free_x     = {3'b000, free_idx_reg};
    assign live_cur   = live_reg[idx_reg];
    assign idx_last   = (idx_reg == IDX_LAST);
    assign scan_hit   = live_cur && (rd.device == dev_reg) && (rd.block == blk_reg);
    assign sweep_cand = live_cur && (rd.refs == '0);
    assign wb_room    = (wb_cnt_reg != WB_W'(MAX_WB));
    assign sweep_wb   = sweep_cand && rd.modified && wb_room;
    assign sweep_free = sweep_cand && (!rd.modified || wb_room);
    assign refs_inc   = (rd.refs == REF_MAX) ? REF_MAX : rd.refs + 8'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_READ: state_next = ST_SCAN;
                        OP_SYNC: state_next = ST_SWEEP;
                        default: state_next = ST_SLOT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    if (emit_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_last)
                begin
                    state_next = (free_found_reg || !live_cur) ? ST_FINISH : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!(sweep_wb && !emit_ok) && idx_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SLOT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory, result and walk controls
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = rd;
        ram_re     = 1'b0;
        ram_raddr  = idx_reg + IDX_W'(1);
        emit       = 1'b0;
        emit_kind  = RK_ACK;
        emit_slot  = '0;
        emit_block = '0;
        emit_refs  = '0;
        emit_last  = 1'b1;
        idx_clr    = 1'b0;
        idx_inc    = 1'b0;
        live_set   = 1'b0;
        live_clr   = 1'b0;
        live_idx   = idx_reg;
        free_rec   = 1'b0;
        wb_inc     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Start the walk at entry 0, or fetch the addressed slot
                if (accept)
                begin
                    ram_re  = 1'b1;
                    idx_clr = 1'b1;
                    if ((in_op == OP_READ) || (in_op == OP_SYNC))
                    begin
                        ram_raddr = '0;
                    end
                    else
                    begin
                        ram_raddr = in_slot_x[IDX_W-1:0];
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    // Take a reference on the matching entry
                    if (emit_ok)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.refs = refs_inc;
                        emit           = 1'b1;
                        emit_kind      = RK_HIT;
                        emit_slot      = idx_x[2:0];
                        emit_block     = blk_reg;
                        emit_refs      = refs_inc;
                    end
                end
                else
                begin
                    free_rec = !live_cur;
                    if (!idx_last)
                    begin
                        ram_re  = 1'b1;
                        idx_inc = 1'b1;
                    end
                    else if (!(free_found_reg || !live_cur))
                    begin
                        // Nothing free: restart the walk for a sync pass
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        idx_clr   = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!(sweep_wb && !emit_ok))
                begin
                    if (sweep_wb)
                    begin
                        emit       = 1'b1;
                        emit_kind  = RK_WRITEBACK;
                        emit_slot  = idx_x[2:0];
                        emit_block = rd.block;
                        emit_last  = 1'b0;
                        wb_inc     = 1'b1;
                    end
                    if (sweep_free)
                    begin
                        live_clr = 1'b1;
                        free_rec = 1'b1;
                    end
                    if (!idx_last)
                    begin
                        ram_re  = 1'b1;
                        idx_inc = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (op_reg == OP_READ)
                    begin
                        if (free_found_reg)
                        begin
                            // Claim the lowest free entry
                            ram_we           = 1'b1;
                            ram_waddr        = free_idx_reg;
                            ram_wdata.modified = 1'b0;
                            ram_wdata.refs   = 8'd1;
                            ram_wdata.block  = blk_reg;
                            ram_wdata.device = dev_reg;
                            live_set         = 1'b1;
                            live_idx         = free_idx_reg;
                            emit_kind        = RK_MISS;
                            emit_slot        = free_x[2:0];
                            emit_block       = blk_reg;
                            emit_refs        = 8'd1;
                        end
                        else
                        begin
                            emit_kind  = RK_NO_FREE;
                            emit_block = blk_reg;
                        end
                    end
                    else
                    begin
                        emit_kind = RK_ACK;
                    end
                end
            end
            ST_SLOT:
            begin
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_slot = slot_reg;
                    if (slot_bad)
                    begin
                        emit_kind = RK_BAD_SLOT;
                    end
                    else
                    begin
                        // Drop a reference or flag the entry modified
                        ram_we    = 1'b1;
                        ram_waddr = slot_idx;
                        if (op_reg == OP_RELEASE)
                        begin
                            ram_wdata.refs = rd.refs - 8'd1;
                        end
                        else
                        begin
                            ram_wdata.modified = 1'b1;
                        end
                        emit_kind  = RK_ACK;
                        emit_block = rd.block;
                        emit_refs  = ram_wdata.refs;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            wb_cnt_reg     <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (accept)
            begin
                free_found_reg <= 1'b0;
                wb_cnt_reg     <= '0;
            end
            else
            begin
                if (free_rec)
                begin
                    free_found_reg <= 1'b1;
                end
                if (wb_inc)
                begin
                    wb_cnt_reg <= wb_cnt_reg + WB_W'(1);
                end
            end
            if (live_set)
            begin
                live_reg[live_idx] <= 1'b1;
            end
            else if (live_clr)
            begin
                live_reg[live_idx] <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            dev_reg  <= s_axis_tdata[7:0];
            blk_reg  <= s_axis_tdata[39:8];
            slot_reg <= in_slot;
        end
        if (free_rec && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_slot_reg  <= emit_slot;
            out_block_reg <= emit_block;
            out_refs_reg  <= emit_refs;
            out_last_reg  <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {5'b00000, out_refs_reg, out_block_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

    // A result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n) emit |-> emit_ok)
        else $error("result loaded over a pending one");

    // Only writebacks leave without tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_kind_reg == RK_WRITEBACK))
        else $error("non-final result is not a writeback");

    // One request emits at most MAX_WB writebacks
    assert property (@(posedge clk) disable iff (!rst_n) wb_cnt_reg <= WB_W'(MAX_WB))
        else $error("writeback count overflow");

    // A closing result returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("closing result without return to idle");

endmodule

### test/block_buffer_cache_tags_checker.sv
`timescale 1ns / 100ps

module block_buffer_cache_tags_checker
    import bbc_pkg::*;
#(
    parameter int ENTRIES = CACHE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // device[7:0], block_number[39:8], slot[42:40]
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // slot_index[2:0], target_block[34:3],
                                        // reference_count[42:35]
    input  logic [2:0]  m_axis_tuser,   // result_kind[2:0]
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          pending_results
);

    typedef enum logic [1:0] {
        SLOT_FREE,
        SLOT_USED,
        SLOT_MODIFIED
    } slot_state_t;

    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0]  block;
        logic [REF_W-1:0]  refs;
        logic              last;
    } cache_result_t;

    // Shadow copy of the tag store
    slot_state_t      tag_state  [ENTRIES];
    logic [DEV_W-1:0] tag_device [ENTRIES];
    logic [BLK_W-1:0] tag_block  [ENTRIES];
    logic [REF_W-1:0] tag_refs   [ENTRIES];

    cache_result_t expected_results [$];
    int            fail_total;

    task automatic queue_result(kind_t kind, int slot, logic [BLK_W-1:0] block,
                                logic [REF_W-1:0] refs);
        cache_result_t r;
        r.kind  = kind;
        r.slot  = slot[SLOT_W-1:0];
        r.block = block;
        r.refs  = refs;
        r.last  = 1'b0;
        expected_results.push_back(r);
    endtask

    function automatic int first_free();
        for (int i = 0; i < ENTRIES; i++)
            if (tag_state[i] == SLOT_FREE)
                return i;
        return -1;
    endfunction

    // Free unreferenced clean entries, and modified ones written back (up to MAX_WB)
    task automatic sweep_unreferenced();
        int writebacks = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tag_state[i] == SLOT_FREE || tag_refs[i] != '0)
                continue;
            if (tag_state[i] == SLOT_MODIFIED)
            begin
                if (writebacks >= MAX_WB)
                    continue;
                queue_result(RK_WRITEBACK, i, tag_block[i], '0);
                writebacks++;
            end
            tag_state[i] = SLOT_FREE;
        end
    endtask

    // Apply one request to the shadow tags and queue the results it causes
    task automatic predict_request(op_t op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                                   logic [SLOT_W-1:0] slot);
        int   hit_at = -1;
        int   free_at;
        logic bad;
        case (op)
            OP_READ:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (hit_at < 0 && tag_state[i] != SLOT_FREE &&
                        tag_device[i] == dev && tag_block[i] == blk)
                        hit_at = i;
                if (hit_at >= 0)
                begin
                    if (tag_refs[hit_at] != REF_MAX)
                        tag_refs[hit_at] = tag_refs[hit_at] + 1'b1;
                    queue_result(RK_HIT, hit_at, blk, tag_refs[hit_at]);
                end
                else
                begin
                    free_at = first_free();
                    if (free_at < 0)
                    begin
                        sweep_unreferenced();
                        free_at = first_free();
                    end
                    if (free_at < 0)
                        queue_result(RK_NO_FREE, 0, blk, '0);
                    else
                    begin
                        tag_state[free_at]  = SLOT_USED;
                        tag_device[free_at] = dev;
                        tag_block[free_at]  = blk;
                        tag_refs[free_at]   = 8'd1;
                        queue_result(RK_MISS, free_at, blk, 8'd1);
                    end
                end
            end
            OP_SYNC:
            begin
                sweep_unreferenced();
                queue_result(RK_ACK, 0, '0, '0);
            end
            default:
            begin
                bad = (int'(slot) >= ENTRIES);
                if (!bad)
                    bad = (tag_state[slot] == SLOT_FREE) ||
                          (op == OP_RELEASE && tag_refs[slot] == '0);
                if (bad)
                    queue_result(RK_BAD_SLOT, int'(slot), '0, '0);
                else
                begin
                    if (op == OP_RELEASE)
                        tag_refs[slot] = tag_refs[slot] - 1'b1;
                    else
                        tag_state[slot] = SLOT_MODIFIED;
                    queue_result(RK_ACK, int'(slot), tag_block[slot], tag_refs[slot]);
                end
            end
        endcase
        expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Compare each accepted result, then predict each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_state[i]  = SLOT_FREE;
                tag_device[i] = '0;
                tag_block[i]  = '0;
                tag_refs[i]   = '0;
            end
            expected_results.delete();
            fail_total = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("unexpected result: kind %0d slot %0d block %h refs %0d last %0b",
                                 m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                                 m_axis_tdata[SLOT_W +: BLK_W],
                                 m_axis_tdata[SLOT_W+BLK_W +: REF_W], m_axis_tlast);
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind ||
                        m_axis_tdata[SLOT_W-1:0] !== want.slot ||
                        m_axis_tdata[SLOT_W +: BLK_W] !== want.block ||
                        m_axis_tdata[SLOT_W+BLK_W +: REF_W] !== want.refs ||
                        m_axis_tlast !== want.last)
                    begin
                        if (fail_total < 10)
                            $display({"result mismatch: expected kind %0d slot %0d block %h ",
                                      "refs %0d last %0b, got kind %0d slot %0d block %h ",
                                      "refs %0d last %0b"},
                                     want.kind, want.slot, want.block, want.refs, want.last,
                                     m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                                     m_axis_tdata[SLOT_W +: BLK_W],
                                     m_axis_tdata[SLOT_W+BLK_W +: REF_W], m_axis_tlast);
                        fail_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_request(op_t'(s_axis_tuser), s_axis_tdata[DEV_W-1:0],
                                s_axis_tdata[DEV_W +: BLK_W],
                                s_axis_tdata[DEV_W+BLK_W +: SLOT_W]);
            mismatch_count  <= fail_total;
            pending_results <= expected_results.size();
        end
    end

endmodule

### test/block_buffer_cache_tags_core_tb.sv
`timescale 1ns / 100ps

module block_buffer_cache_tags_core_tb
    import bbc_pkg::*;
();

    localparam int CYCLE_LIMIT      = 300000;
    localparam int DRAIN_CYCLES     = 2 * CACHE_ENTRIES_DEF + 8;
    localparam int TAG_POOL         = 12;
    localparam int RANDOM_PER_PHASE = 79;
    localparam int PAD_W            = 48 - DEV_W - BLK_W - SLOT_W;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int mismatch_count;
    int pending_results;

    // Tags that random reads come back to, so hits and full-cache sweeps occur
    logic [DEV_W-1:0] pool_device [TAG_POOL];
    logic [BLK_W-1:0] pool_block  [TAG_POOL];

    block_buffer_cache_tags_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    block_buffer_cache_tags_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("block_buffer_cache_tags_core_tb failed");
            $finish;
        end
    end

    // Present one request, holding it until accepted
    task automatic send_request(op_t op, logic [DEV_W-1:0] dev, logic [BLK_W-1:0] blk,
                                logic [SLOT_W-1:0] slot);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {{PAD_W{1'b0}}, slot, blk, dev};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int pick;
        int tag;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_READ;
        for (int i = 0; i < TAG_POOL; i++)
        begin
            pool_device[i] = 8'($urandom_range(255));
            pool_block[i]  = $urandom;
        end
        send_idle_pct = 6;
        recv_idle_pct = 58;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty cache: sync finds nothing, release and mark of free slots fail
        send_request(OP_SYNC, '0, '0, '0);
        send_request(OP_RELEASE, '0, '0, 3'd7);
        send_request(OP_MARK, 8'hFF, 32'hFFFF_FFFF, 3'd0);
        // Fill the cache; the repeated tag hits
        send_request(OP_READ, 8'h00, 32'h0000_0000, 3'd0);
        send_request(OP_READ, 8'hFF, 32'hFFFF_FFFF, 3'd7);
        send_request(OP_READ, 8'h00, 32'h0000_0000, 3'd0);
        // Same block on another device is a miss
        send_request(OP_READ, 8'hFF, 32'h0000_0000, 3'd0);
        for (int i = 3; i < 8; i++)
            send_request(OP_READ, 8'(i * 37), 32'h8000_0000 + i, 3'(i));
        // Take one reference back from entry 0
        send_request(OP_RELEASE, '0, '0, 3'd0);
        // Every entry referenced: the sweep frees nothing
        send_request(OP_READ, 8'h3C, 32'h1234_5678, 3'd0);
        // Entry 1 drops to zero, a second release fails, mark it modified while unreferenced
        send_request(OP_RELEASE, '0, '0, 3'd1);
        send_request(OP_RELEASE, '0, '0, 3'd1);
        send_request(OP_MARK, '0, '0, 3'd1);
        // Entry 2 modified and unreferenced, entry 3 clean and unreferenced
        send_request(OP_MARK, '0, '0, 3'd2);
        send_request(OP_RELEASE, '0, '0, 3'd2);
        send_request(OP_RELEASE, '0, '0, 3'd3);
        // Miss on a full cache: write back 1 and 2, free 3, claim 1
        send_request(OP_READ, 8'h3C, 32'h1234_5678, 3'd0);
        // Writeback from a plain sync
        send_request(OP_RELEASE, '0, '0, 3'd7);
        send_request(OP_MARK, '0, '0, 3'd7);
        send_request(OP_SYNC, '0, '0, '0);

        // Random traffic, reads mostly on the tag pool, in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                tag  = $urandom_range(TAG_POOL - 1);
                if (pick < 45)
                begin
                    if ($urandom_range(99) < 85)
                        send_request(OP_READ, pool_device[tag], pool_block[tag],
                                     3'($urandom_range(7)));
                    else
                        send_request(OP_READ, 8'($urandom_range(255)), $urandom,
                                     3'($urandom_range(7)));
                end
                else if (pick < 75)
                    send_request(OP_RELEASE, 8'($urandom_range(255)), $urandom,
                                 3'($urandom_range(7)));
                else if (pick < 88)
                    send_request(OP_MARK, 8'($urandom_range(255)), $urandom,
                                 3'($urandom_range(7)));
                else
                    send_request(OP_SYNC, 8'($urandom_range(255)), $urandom,
                                 3'($urandom_range(7)));
            end
        end
        s_axis_tvalid = 1'b0;

        // Drain the outstanding results, then watch for strays
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("block_buffer_cache_tags_core_tb passed");
        else
            $display("block_buffer_cache_tags_core_tb failed");
        $finish;
    end

endmodule

### block_buffer_cache_tags_core.f
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/block_buffer_cache_tags_core.sv
test/block_buffer_cache_tags_checker.sv
test/block_buffer_cache_tags_core_tb.sv
